@@ design/message_ring_with_read_transform_top_defines.svh @@
// Assertion macros used by the message ring control (mrt_ctrl).
`ifndef MESSAGE_RING_WITH_READ_TRANSFORM_TOP_DEFINES_SVH
`define MESSAGE_RING_WITH_READ_TRANSFORM_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mrt_pkg.sv @@
// Types and constants of the message ring with read transform.
package mrt_pkg;

    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 3;
    localparam int MODE_W   = 2;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNC   = 2'd3;

    // transform modes; the unused code behaves as MODE_PLAIN
    localparam logic [MODE_W-1:0] MODE_PLAIN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UPPER   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd2;

    localparam logic [DATA_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [DATA_W-1:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [DATA_W-1:0] CASE_OFFSET  = 8'd32;

    localparam logic [OCC_W-1:0] OCC_MAX = 3'd7;

    typedef struct packed {
        logic              operation;
        logic [DATA_W-1:0] data_in;
        logic              end_of_message;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0]   data_out;
        logic [STATUS_W-1:0] status;
        logic                last_of_message;
        logic [OCC_W-1:0]    occupancy;
    } result_t;

endpackage

@@ design/mrt_in_if.sv @@
// Input channel: one write or read request word.
interface mrt_in_if;
    import mrt_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [DATA_W-1:0] data_in;
    logic              end_of_message;

    modport source (output valid, operation, data_in, end_of_message, input ready);
    modport sink   (input valid, operation, data_in, end_of_message, output ready);
endinterface

@@ design/mrt_out_if.sv @@
// Output channel: one result word.
interface mrt_out_if;
    import mrt_pkg::*;

    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   data_out;
    logic [STATUS_W-1:0] status;
    logic                last_of_message;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, data_out, status, last_of_message, occupancy, input ready);
    modport sink   (input valid, data_out, status, last_of_message, occupancy, output ready);
endinterface

@@ design/mrt_ram.sv @@
// Generic simple dual-port RAM with registered read.
module mrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/mrt_ctrl.sv @@
// Ring control: slot and cursor state, drop logic, read sequencer and transform.
`include "message_ring_with_read_transform_top_defines.svh"

module mrt_ctrl #(
    parameter int SLOTS     = 8,
    parameter int MSG_BYTES = 256,
    localparam int SW = $clog2(SLOTS),
    localparam int LW = $clog2(MSG_BYTES + 1),
    localparam int CW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1,
    localparam int AW = (SLOTS * MSG_BYTES > 1) ? $clog2(SLOTS * MSG_BYTES) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        acc,
    input  mrt_pkg::item_t              item,
    input  logic [mrt_pkg::MODE_W-1:0]  mode,
    output logic                        idle,
    output logic                        res_valid,
    output mrt_pkg::result_t            res,
    // message store
    output logic                        st_we,
    output logic [AW-1:0]               st_waddr,
    output logic [mrt_pkg::DATA_W-1:0]  st_wdata,
    output logic                        st_re,
    output logic [AW-1:0]               st_raddr,
    input  logic [mrt_pkg::DATA_W-1:0]  st_rdata,
    // length table
    output logic                        ln_we,
    output logic [SW-1:0]               ln_waddr,
    output logic [LW-1:0]               ln_wdata,
    output logic                        ln_re,
    output logic [SW-1:0]               ln_raddr,
    input  logic [LW-1:0]               ln_rdata
);
    import mrt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LEN  = 2'd1;
    localparam logic [1:0] S_BYTE = 2'd2;

    localparam logic [AW-1:0] MSG_A  = AW'(MSG_BYTES);
    localparam logic [LW-1:0] MSG_L  = LW'(MSG_BYTES);

    logic [1:0]    state_reg, state_next;
    logic [SW-1:0] ws_reg, ws_next;
    logic [SW-1:0] rs_reg, rs_next;
    logic [LW-1:0] wc_reg, wc_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] rc_reg, rc_next;
    logic          stop_reg, stop_next;
    logic          done_reg, done_next;

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        return (s == SW'(SLOTS - 1)) ? '0 : s + SW'(1);
    endfunction

    // committed messages waiting, saturated
    function automatic logic [OCC_W-1:0] occ_of(input logic [SW-1:0] w,
                                                input logic [SW-1:0] r);
        logic [7:0] d;
        d = 8'(w) - 8'(r);
        if (w < r)
        begin
            d = d + 8'(SLOTS);
        end
        return (d > 8'(OCC_MAX)) ? OCC_MAX : d[OCC_W-1:0];
    endfunction

    always_comb
    begin
        logic          dropping;
        logic [LW-1:0] wc_inc;
        logic [LW-1:0] rc_l;
        logic [LW-1:0] pos_l;
        logic [DATA_W-1:0] byte_v;

        state_next = state_reg;
        ws_next    = ws_reg;
        rs_next    = rs_reg;
        wc_next    = wc_reg;
        drop_next  = drop_reg;
        rc_next    = rc_reg;
        stop_next  = stop_reg;
        done_next  = done_reg;

        res       = '0;
        res_valid = 1'b0;

        st_we    = 1'b0;
        st_waddr = AW'(ws_reg) * MSG_A + AW'(wc_reg);
        st_wdata = item.data_in;
        st_re    = 1'b0;
        st_raddr = '0;
        ln_we    = 1'b0;
        ln_waddr = ws_reg;
        ln_re    = 1'b0;
        ln_raddr = rs_reg;

        wc_inc   = wc_reg + LW'(1);
        ln_wdata = wc_reg;
        rc_l     = LW'(rc_reg);
        pos_l    = rc_l;
        byte_v   = st_rdata;
        dropping = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (item.operation == OP_WRITE)
                    begin
                        res_valid = 1'b1;
                        dropping  = drop_reg ||
                                    (wc_reg == '0 && next_slot(ws_reg) == rs_reg);
                        if (dropping)
                        begin
                            res.status = ST_DROPPED;
                            drop_next  = !item.end_of_message;
                        end
                        else
                        begin
                            if (wc_reg < MSG_L)
                            begin
                                st_we      = 1'b1;
                                wc_next    = wc_inc;
                                ln_wdata   = wc_inc;
                                res.status = ST_OK;
                            end
                            else
                            begin
                                res.status = ST_TRUNC;
                            end
                            if (item.end_of_message)
                            begin
                                ln_we   = 1'b1;
                                ws_next = next_slot(ws_reg);
                                wc_next = '0;
                            end
                        end
                    end
                    else if (rs_reg == ws_reg)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_EMPTY;
                    end
                    else
                    begin
                        ln_re      = 1'b1;
                        stop_next  = item.end_of_message;
                        state_next = S_LEN;
                    end
                end
            end
            S_LEN:
            begin
                if (mode == MODE_REVERSE)
                begin
                    pos_l = ln_rdata - LW'(1) - rc_l;
                end
                st_re      = 1'b1;
                st_raddr   = AW'(rs_reg) * MSG_A + AW'(pos_l);
                done_next  = stop_reg || (rc_l + LW'(1) >= ln_rdata);
                state_next = S_BYTE;
            end
            S_BYTE:
            begin
                if (mode == MODE_UPPER && byte_v >= CHAR_LOWER_A && byte_v <= CHAR_LOWER_Z)
                begin
                    byte_v = byte_v - CASE_OFFSET;
                end
                res_valid           = 1'b1;
                res.data_out        = byte_v;
                res.status          = ST_OK;
                res.last_of_message = done_reg;
                if (done_reg)
                begin
                    rs_next = next_slot(rs_reg);
                    rc_next = '0;
                end
                else
                begin
                    rc_next = rc_reg + CW'(1);
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.occupancy = occ_of(ws_next, rs_next);
    end

    assign idle = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ws_reg    <= '0;
            rs_reg    <= '0;
            wc_reg    <= '0;
            drop_reg  <= 1'b0;
            rc_reg    <= '0;
            stop_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ws_reg    <= ws_next;
            rs_reg    <= rs_next;
            wc_reg    <= wc_next;
            drop_reg  <= drop_next;
            rc_reg    <= rc_next;
            stop_reg  <= stop_next;
            done_reg  <= done_next;
        end
    end

    `MRT_ASSERT_SAME(a_acc_idle, clk, rst_n, acc, state_reg == S_IDLE, "word taken while busy")
    `MRT_ASSERT_NEXT(a_len_then_byte, clk, rst_n, state_reg == S_LEN, res_valid, "read result missing")
    `MRT_ASSERT_SAME(a_wc_range, clk, rst_n, 1'b1, wc_reg <= MSG_L, "write cursor overrun")
    `MRT_ASSERT_SAME(a_empty_clean, clk, rst_n, res_valid && res.status == ST_EMPTY, res.data_out == '0 && !res.last_of_message, "empty read carries data")

endmodule

@@ design/message_ring_with_read_transform_top.sv @@
// Top level of the message ring with read transform.
// Results: a write word's result goes straight into the output register; a read word
// goes through the length table read, then the store read, then the output register.
// Throughput: one write word per cycle while the output register is empty or draining;
// a read word holds off new words until its result is formed. Empty reads skip memory.
// Reset: control state and transform mode clear asynchronously; store and length
// memories are not cleared and are only read at entries a committed message wrote.
module message_ring_with_read_transform_top #(
    parameter int SLOTS     = 8,
    parameter int MSG_BYTES = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    mrt_in_if.sink                     in_ch,
    mrt_out_if.source                  out_ch,
    input  logic                       cfg_we,
    input  logic [mrt_pkg::MODE_W-1:0] cfg_data
);
    import mrt_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int LW = $clog2(MSG_BYTES + 1);
    localparam int SD = SLOTS * MSG_BYTES;
    localparam int AW = (SD > 1) ? $clog2(SD) : 1;

    logic [MODE_W-1:0] mode_reg;
    result_t           out_reg;
    logic              out_valid_reg;

    item_t   item;
    result_t res;
    logic    res_valid;
    logic    idle;
    logic    acc;

    // store and length table ports
    logic              st_we, st_re;
    logic [AW-1:0]     st_waddr, st_raddr;
    logic [DATA_W-1:0] st_wdata, st_rdata;
    logic              ln_we, ln_re;
    logic [SW-1:0]     ln_waddr, ln_raddr;
    logic [LW-1:0]     ln_wdata, ln_rdata;

    // Take a new word only when the sequencer is idle and the output
    // register is empty or draining this cycle.
    assign in_ch.ready = idle && (!out_valid_reg || out_ch.ready);
    assign acc         = in_ch.valid && in_ch.ready;

    assign item.operation      = in_ch.operation;
    assign item.data_in        = in_ch.data_in;
    assign item.end_of_message = in_ch.end_of_message;

    // transform mode register; written by user only while block is idle; unenforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
        end
    end

    mrt_ctrl #(
        .SLOTS     (SLOTS),
        .MSG_BYTES (MSG_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .item      (item),
        .mode      (mode_reg),
        .idle      (idle),
        .res_valid (res_valid),
        .res       (res),
        .st_we     (st_we),
        .st_waddr  (st_waddr),
        .st_wdata  (st_wdata),
        .st_re     (st_re),
        .st_raddr  (st_raddr),
        .st_rdata  (st_rdata),
        .ln_we     (ln_we),
        .ln_waddr  (ln_waddr),
        .ln_wdata  (ln_wdata),
        .ln_re     (ln_re),
        .ln_raddr  (ln_raddr),
        .ln_rdata  (ln_rdata)
    );

    // message bytes, one MSG_BYTES region per slot
    mrt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SD)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // committed length per slot
    mrt_ram #(
        .WIDTH (LW),
        .DEPTH (SLOTS)
    ) u_lengths (
        .clk   (clk),
        .we    (ln_we),
        .waddr (ln_waddr),
        .wdata (ln_wdata),
        .re    (ln_re),
        .raddr (ln_raddr),
        .rdata (ln_rdata)
    );

    // output register: one result word per request word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.data_out        = out_reg.data_out;
    assign out_ch.status          = out_reg.status;
    assign out_ch.last_of_message = out_reg.last_of_message;
    assign out_ch.occupancy       = out_reg.occupancy;

endmodule

@@ tb/message_ring_with_read_transform_top_tb.sv @@
// Self-checking testbench for the message ring: directed table, then random message traffic.
module message_ring_with_read_transform_top_tb;
    import mrt_pkg::*;

    localparam int SLOTS        = 8;
    localparam int MSG_BYTES    = 256;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int HOLD_CYCLES  = 80;    // long receiver hold-off, fills the block
    localparam int END_CYCLES   = 10;    // margin after the last result
    localparam int WDOG_LIMIT   = 1000;  // cycles with no word moving on either side
    localparam int DIR_ROWS     = 25;

    // the spare mode code, expected to act like MODE_PLAIN
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [MODE_W-1:0] cfg_data;

    mrt_in_if  in_ch();
    mrt_out_if out_ch();

    message_ring_with_read_transform_top #(
        .SLOTS     (SLOTS),
        .MSG_BYTES (MSG_BYTES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // 20 time unit period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Ring model: own copy of the store, lengths, pointers and mode.
    // Entries are only read once a committed message wrote them.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] ring_bytes [SLOTS*MSG_BYTES];
    logic [8:0]        ring_len   [SLOTS];
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
    logic [8:0]        wr_cursor;
    logic [7:0]        rd_cursor;
    logic              dropping;
    logic [MODE_W-1:0] model_mode;

    result_t ring_results_due [$];   // expected result words, oldest first
    int      errors = 0;

    // knobs shared between the stimulus thread and the receiver
    bit sender_idle_en = 1'b1;
    bit sink_idle_en   = 1'b1;
    bit hold_req       = 1'b0;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return SLOT_W'((int'(s) + 1) % SLOTS);
    endfunction

    // Apply one accepted word to the model and return the result it causes.
    function automatic result_t ring_predict(input item_t w);
        result_t    r;
        logic [8:0] len;
        logic [8:0] pos;
        logic [7:0] b;
        logic       done;
        int         occ;
        r = '0;
        if (w.operation == OP_READ)
        begin
            if (rd_slot == wr_slot)
            begin
                r.status = ST_EMPTY;          // nothing committed, state untouched
            end
            else
            begin
                len = ring_len[rd_slot];
                pos = (model_mode == MODE_REVERSE) ? (len - 9'd1 - {1'b0, rd_cursor})
                                                   : {1'b0, rd_cursor};
                b = ring_bytes[int'(rd_slot) * MSG_BYTES + int'(pos)];
                if (model_mode == MODE_UPPER && b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z)
                    b = b - CASE_OFFSET;
                // stop flag frees the slot early, rest of message discarded
                done = w.end_of_message || (int'(rd_cursor) + 1 >= int'(len));
                if (done)
                begin
                    rd_slot   = next_slot(rd_slot);
                    rd_cursor = '0;
                end
                else
                begin
                    rd_cursor = rd_cursor + 8'd1;
                end
                r.data_out        = b;
                r.status          = ST_OK;
                r.last_of_message = done;
            end
        end
        else
        begin
            // a message that starts on a full ring is dropped up to its final byte
            if (wr_cursor == 0 && !dropping && next_slot(wr_slot) == rd_slot)
                dropping = 1'b1;
            if (dropping)
            begin
                r.status = ST_DROPPED;
                if (w.end_of_message)
                    dropping = 1'b0;
            end
            else
            begin
                if (int'(wr_cursor) < MSG_BYTES)
                begin
                    ring_bytes[int'(wr_slot) * MSG_BYTES + int'(wr_cursor)] = w.data_in;
                    wr_cursor = wr_cursor + 9'd1;
                    r.status  = ST_OK;
                end
                else
                begin
                    r.status = ST_TRUNC;      // overlong: byte not stored
                end
                if (w.end_of_message)
                begin
                    ring_len[wr_slot] = wr_cursor;
                    wr_slot   = next_slot(wr_slot);
                    wr_cursor = '0;
                end
            end
        end
        occ = (int'(wr_slot) + SLOTS - int'(rd_slot)) % SLOTS;
        r.occupancy = (occ > int'(OCC_MAX)) ? OCC_MAX : OCC_W'(occ);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Rows either send a word or change the mode.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic              is_mode;
        logic [MODE_W-1:0] mode;
        item_t             word;
        logic              typed;     // res holds a hand-written expectation
        result_t           res;
    } dir_row_t;

    dir_row_t dir_rows [DIR_ROWS];

    function automatic item_t mk_item(input logic op, input logic [7:0] d, input logic eom);
        item_t w;
        w.operation      = op;
        w.data_in        = d;
        w.end_of_message = eom;
        return w;
    endfunction

    function automatic dir_row_t word_row(input logic op, input logic [7:0] d,
                                          input logic eom);
        dir_row_t row;
        row = '0;
        row.word = mk_item(op, d, eom);
        return row;
    endfunction

    function automatic dir_row_t typed_row(input logic op, input logic [7:0] d,
                                           input logic eom, input result_t r);
        dir_row_t row;
        row = word_row(op, d, eom);
        row.typed = 1'b1;
        row.res   = r;
        return row;
    endfunction

    function automatic dir_row_t mode_row(input logic [MODE_W-1:0] m);
        dir_row_t row;
        row = '0;
        row.is_mode = 1'b1;
        row.mode    = m;
        return row;
    endfunction

    // bytes near the lower-case range (so both case edges get hit), near upper case, or any value
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(8'h5e, 8'h7d));
            1:       return 8'($urandom_range(8'h40, 8'h5b));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender. Payload changes on the falling edge; a word counts as taken
    // on the rising edge where valid and ready are both high. The model is
    // updated at that moment, so its state always matches what was sent.
    // ------------------------------------------------------------------
    task automatic send_word(input item_t w, input logic typed = 1'b0,
                             input result_t typed_res = '0);
        result_t r;
        if (sender_idle_en && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.operation      <= w.operation;
        in_ch.data_in        <= w.data_in;
        in_ch.end_of_message <= w.end_of_message;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        r = ring_predict(w);
        ring_results_due.push_back(typed ? typed_res : r);
        @(negedge clk);
    endtask

    // Drop valid and wait for every outstanding result word.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (ring_results_due.size() != 0)
            @(negedge clk);
    endtask

    // Mode register is only written with the block idle.
    task automatic load_mode(input logic [MODE_W-1:0] m);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(negedge clk);
        cfg_we     <= 1'b0;
        model_mode  = m;
    endtask

    // Random traffic: whole messages, read bursts with the odd early stop,
    // and some unstructured noise. write_pct steers the ring toward full
    // or toward empty.
    task automatic run_phase(input int n_items, input int write_pct);
        int sent;
        int pick;
        int len;
        int k;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < write_pct)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24)
                                                  : $urandom_range(1, 10);
                for (k = 0; k < len; k++)
                    send_word(mk_item(OP_WRITE, rand_byte(), k == len - 1));
                sent += len;
            end
            else if (pick < 90)
            begin
                len = $urandom_range(1, 12);
                for (k = 0; k < len; k++)
                    send_word(mk_item(OP_READ, 8'($urandom_range(0, 255)),
                                      $urandom_range(0, 9) == 0));
                sent += len;
            end
            else
            begin
                send_word(mk_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1))));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready changes on the falling edge. Short random stalls,
    // plus one long hold-off on request so the block backs up into its
    // input.
    // ------------------------------------------------------------------
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Every result word is matched against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (ring_results_due.size() == 0)
            begin
                $display("%0t: result word with nothing expected, expected none actual %0h",
                         $time, {out_ch.data_out, out_ch.status,
                                 out_ch.last_of_message, out_ch.occupancy});
                errors++;
            end
            else
            begin
                want = ring_results_due.pop_front();
                check_field("data_out", want.data_out, out_ch.data_out);
                check_field("status", want.status, out_ch.status);
                check_field("last_of_message", want.last_of_message,
                            out_ch.last_of_message);
                check_field("occupancy", want.occupancy, out_ch.occupancy);
            end
        end
    end

    // Watchdog: too long with no word moving on either channel ends the run.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no progress for %0d cycles", $time, WDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        int k;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_data             = MODE_PLAIN;
        in_ch.valid          = 1'b0;
        in_ch.operation      = OP_WRITE;
        in_ch.data_in        = '0;
        in_ch.end_of_message = 1'b0;

        wr_slot    = '0;
        rd_slot    = '0;
        wr_cursor  = '0;
        rd_cursor  = '0;
        dropping   = 1'b0;
        model_mode = MODE_PLAIN;

        // After reset: empty read, a two-byte message and its read-back at the
        // byte extremes, then seven messages to fill the ring, a message
        // dropped on the full ring, and reads under changing modes including
        // a mode change and an early stop in the middle of one message.
        dir_rows = '{
            typed_row(OP_READ,  8'ha5, 1'b0, result_t'{8'h00, ST_EMPTY,   1'b0, 3'd0}),
            typed_row(OP_WRITE, 8'h00, 1'b0, result_t'{8'h00, ST_OK,      1'b0, 3'd0}),
            typed_row(OP_WRITE, 8'hff, 1'b1, result_t'{8'h00, ST_OK,      1'b0, 3'd1}),
            typed_row(OP_READ,  8'hff, 1'b0, result_t'{8'h00, ST_OK,      1'b0, 3'd1}),
            typed_row(OP_READ,  8'h00, 1'b0, result_t'{8'hff, ST_OK,      1'b1, 3'd0}),
            word_row (OP_WRITE, CHAR_LOWER_A, 1'b0),
            word_row (OP_WRITE, 8'h62, 1'b0),                 // 'b'
            word_row (OP_WRITE, CHAR_LOWER_Z, 1'b1),
            word_row (OP_WRITE, 8'h7b, 1'b1),                 // just above 'z'
            word_row (OP_WRITE, 8'h60, 1'b1),                 // just below 'a'
            word_row (OP_WRITE, 8'h41, 1'b1),                 // 'A'
            word_row (OP_WRITE, 8'h5a, 1'b1),                 // 'Z'
            word_row (OP_WRITE, 8'h30, 1'b1),
            typed_row(OP_WRITE, 8'h80, 1'b1, result_t'{8'h00, ST_OK,      1'b0, 3'd7}),
            typed_row(OP_WRITE, 8'h11, 1'b0, result_t'{8'h00, ST_DROPPED, 1'b0, 3'd7}),
            typed_row(OP_WRITE, 8'h22, 1'b1, result_t'{8'h00, ST_DROPPED, 1'b0, 3'd7}),
            mode_row (MODE_UPPER),
            word_row (OP_READ,  8'h3c, 1'b0),
            mode_row (MODE_REVERSE),
            word_row (OP_READ,  8'hc3, 1'b1),                 // stop mid-message
            mode_row (MODE_UNUSED),
            word_row (OP_READ,  8'h00, 1'b0),
            mode_row (MODE_UPPER),
            word_row (OP_READ,  8'hff, 1'b0),
            word_row (OP_READ,  8'h00, 1'b0)
        };

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].is_mode)
                load_mode(dir_rows[i].mode);
            else
                send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);
        end

        // balanced traffic, plain bytes
        load_mode(MODE_PLAIN);
        run_phase(30, 50);

        // receiver holds off while the sender keeps pushing writes, then
        // a read-heavy stretch empties the ring again
        load_mode(MODE_UPPER);
        hold_req = 1'b1;
        run_phase(30, 80);
        run_phase(20, 20);

        // overlong message read back reversed: close any open message,
        // empty the ring so the long one is stored, write past the slot
        // size, then read its last stored byte, stop on the next one, and
        // read the empty ring once
        load_mode(MODE_REVERSE);
        if (wr_cursor != 0 || dropping)
            send_word(mk_item(OP_WRITE, rand_byte(), 1'b1));
        while (wr_slot != rd_slot)
            send_word(mk_item(OP_READ, 8'($urandom_range(0, 255)), 1'b1));
        for (k = 0; k < MSG_BYTES + 3; k++)
            send_word(mk_item(OP_WRITE, rand_byte(), k == MSG_BYTES + 2));
        for (k = 0; k < 3; k++)
            send_word(mk_item(OP_READ, 8'($urandom_range(0, 255)), k == 1));
        run_phase(20, 50);

        load_mode(MODE_UNUSED);
        run_phase(20, 50);

        // last stretch at full rate on both sides
        load_mode(MODE_REVERSE);
        sender_idle_en = 1'b0;
        sink_idle_en   = 1'b0;
        run_phase(30, 50);

        wait_drained();
        repeat (END_CYCLES) @(negedge clk);
        if (ring_results_due.size() != 0)
        begin
            $display("%0t: results never arrived, expected %0d actual 0",
                     $time, ring_results_due.size());
            errors++;
        end
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
